@@ rtl/brapq_pkg.sv @@
// ----------------------------------------------------------------------------
// brapq_pkg: shared types and constants
// Item formats, controller states and the command/status groups between the
// controller and the datapath of the blocked range-add / point-query unit.
// ----------------------------------------------------------------------------
package brapq_pkg;

    localparam int MAX_SIZE_DEF   = 1024;
    localparam int BLOCK_SIZE_DEF = 32;

    localparam int IDX_W  = 11;
    localparam int DATA_W = 32;

    localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic [IDX_W-1:0]         left;
        logic [IDX_W-1:0]         right;
        logic signed [DATA_W-1:0] amount;
        logic [IDX_W-1:0]         position;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_WALK_FIRST,
        ST_WALK_BLOCKS,
        ST_WALK_LAST,
        ST_POST
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEG_FIRST,
        SEG_BLOCKS,
        SEG_LAST
    } seg_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic walk_start;
        seg_t seg;
        logic post;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic bad;
        logic is_query;
        logic split;
        logic has_blocks;
        logic walk_busy;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/brapq_ctrl.sv @@
// ----------------------------------------------------------------------------
// brapq_ctrl: sequencer
// Runs the clearing pass, takes one item at a time, orders the one to three
// walks of a range add and posts the result into the output register.
// ----------------------------------------------------------------------------
module brapq_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  brapq_pkg::dp_status_t  st,
    output brapq_pkg::dp_cmd_t     cmd
);

    brapq_pkg::ctrl_state_t state_reg;
    brapq_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brapq_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.clear      = 1'b0;
        cmd.load       = 1'b0;
        cmd.walk_start = 1'b0;
        cmd.seg        = brapq_pkg::SEG_FIRST;
        cmd.post       = 1'b0;
        in_stall       = 1'b1;

        case (state_reg)
            brapq_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clear_last)
                begin
                    state_next = brapq_pkg::ST_IDLE;
                end
            end
            brapq_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = brapq_pkg::ST_DECIDE;
                end
            end
            brapq_pkg::ST_DECIDE:
            begin
                // query data is read during this cycle
                if (st.bad || st.is_query)
                begin
                    state_next = brapq_pkg::ST_POST;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    cmd.seg        = brapq_pkg::SEG_FIRST;
                    state_next     = brapq_pkg::ST_WALK_FIRST;
                end
            end
            brapq_pkg::ST_WALK_FIRST:
            begin
                if (!st.walk_busy)
                begin
                    if (!st.split)
                    begin
                        state_next = brapq_pkg::ST_POST;
                    end
                    else if (st.has_blocks)
                    begin
                        cmd.walk_start = 1'b1;
                        cmd.seg        = brapq_pkg::SEG_BLOCKS;
                        state_next     = brapq_pkg::ST_WALK_BLOCKS;
                    end
                    else
                    begin
                        cmd.walk_start = 1'b1;
                        cmd.seg        = brapq_pkg::SEG_LAST;
                        state_next     = brapq_pkg::ST_WALK_LAST;
                    end
                end
            end
            brapq_pkg::ST_WALK_BLOCKS:
            begin
                if (!st.walk_busy)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.seg        = brapq_pkg::SEG_LAST;
                    state_next     = brapq_pkg::ST_WALK_LAST;
                end
            end
            brapq_pkg::ST_WALK_LAST:
            begin
                if (!st.walk_busy)
                begin
                    state_next = brapq_pkg::ST_POST;
                end
            end
            brapq_pkg::ST_POST:
            begin
                if (st.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = brapq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brapq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/brapq_dp.sv @@
// ----------------------------------------------------------------------------
// brapq_dp: datapath
// Element and block-total memories, the address walker with its delayed
// read-modify-write, bounds checks, the size register and the output register.
// ----------------------------------------------------------------------------
module brapq_dp
#(
    parameter int MAX_SIZE   = brapq_pkg::MAX_SIZE_DEF,
    parameter int BLOCK_SIZE = brapq_pkg::BLOCK_SIZE_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [brapq_pkg::IDX_W-1:0]        cfg_data,
    input  brapq_pkg::in_item_t                in_item,
    input  logic                               out_stall,
    output logic                               out_valid,
    output brapq_pkg::out_item_t               out_item,
    input  brapq_pkg::dp_cmd_t                 cmd,
    output brapq_pkg::dp_status_t              st
);

    localparam int BLK_COUNT  = (MAX_SIZE + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int EAW        = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int BAW        = (BLK_COUNT > 1) ? $clog2(BLK_COUNT) : 1;
    localparam int LOG_B      = $clog2(BLOCK_SIZE);
    localparam int IW         = brapq_pkg::IDX_W;
    localparam int DW         = brapq_pkg::DATA_W;

    localparam logic [EAW-1:0] BMASK     = EAW'(BLOCK_SIZE - 1);
    localparam logic [EAW-1:0] LAST_ELEM = EAW'(MAX_SIZE - 1);
    localparam logic [EAW-1:0] LAST_BLK  = EAW'(BLK_COUNT - 1);

    logic [DW-1:0] elem_mem [MAX_SIZE];
    logic [DW-1:0] blk_mem  [BLK_COUNT];

    logic [IW-1:0]        size_reg;
    brapq_pkg::in_item_t  item_reg;
    logic [EAW-1:0]       clear_cnt_reg;
    logic                 walk_active_reg;
    logic                 walk_blk_reg;
    logic [EAW-1:0]       cur_reg;
    logic [EAW-1:0]       last_reg;
    logic                 wr_pend_reg;
    logic                 wr_blk_reg;
    logic [EAW-1:0]       wr_addr_reg;
    logic [DW-1:0]        elem_rd_reg;
    logic [DW-1:0]        blk_rd_reg;
    logic                 out_valid_reg;
    brapq_pkg::out_item_t out_reg;
    brapq_pkg::out_item_t out_next;

    logic [IW-1:0]  n_lim;
    logic [EAW-1:0] l0;
    logic [EAW-1:0] r0;
    logic [EAW-1:0] p0;
    logic [EAW-1:0] bl_w;
    logic [EAW-1:0] br_w;
    logic [EAW-1:0] elem_ra;
    logic [EAW-1:0] blk_ra_w;
    logic           elem_we;
    logic           blk_we;
    logic [EAW-1:0] wa;
    logic [DW-1:0]  wd_elem;
    logic [DW-1:0]  wd_blk;
    logic           add_bad;
    logic           query_bad;

    // bounds
    always_comb
    begin
        if ({21'b0, size_reg} > 32'(MAX_SIZE))
        begin
            n_lim = IW'(MAX_SIZE);
        end
        else
        begin
            n_lim = size_reg;
        end
    end

    assign l0   = EAW'(item_reg.left - IW'(1));
    assign r0   = EAW'(item_reg.right - IW'(1));
    assign p0   = EAW'(item_reg.position - IW'(1));
    assign bl_w = l0 >> LOG_B;
    assign br_w = r0 >> LOG_B;

    assign add_bad   = (item_reg.left == '0) || (item_reg.left > item_reg.right) ||
                       (item_reg.right > n_lim);
    assign query_bad = (item_reg.position == '0) || (item_reg.position > n_lim);

    assign st.is_query   = (item_reg.opcode == brapq_pkg::OP_QUERY);
    assign st.bad        = st.is_query ? query_bad : add_bad;
    assign st.split      = (bl_w != br_w);
    assign st.has_blocks = ((br_w - bl_w) > EAW'(1));
    assign st.walk_busy  = walk_active_reg || wr_pend_reg;
    assign st.clear_last = (clear_cnt_reg == LAST_ELEM);
    assign st.out_free   = !out_valid_reg || !out_stall;

    // memory port selection
    assign elem_ra  = walk_active_reg ? cur_reg : p0;
    assign blk_ra_w = walk_active_reg ? cur_reg : (p0 >> LOG_B);
    assign wa       = cmd.clear ? clear_cnt_reg : wr_addr_reg;
    assign elem_we  = cmd.clear || (wr_pend_reg && !wr_blk_reg);
    assign blk_we   = (cmd.clear && (clear_cnt_reg <= LAST_BLK)) ||
                      (wr_pend_reg && wr_blk_reg);
    assign wd_elem  = cmd.clear ? '0 : (elem_rd_reg + $unsigned(item_reg.amount));
    assign wd_blk   = cmd.clear ? '0 : (blk_rd_reg + $unsigned(item_reg.amount));

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[wa] <= wd_elem;
        end
        elem_rd_reg <= elem_mem[elem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[BAW'(wa)] <= wd_blk;
        end
        blk_rd_reg <= blk_mem[BAW'(blk_ra_w)];
    end

    // configuration and captured item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= brapq_pkg::SIZE_RESET;
        end
        else if (cfg_write)
        begin
            size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clear_cnt_reg <= clear_cnt_reg + EAW'(1);
        end
    end

    // walker: read at cur, write back in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_active_reg <= 1'b0;
            wr_pend_reg     <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= walk_active_reg;
            if (cmd.walk_start)
            begin
                walk_active_reg <= 1'b1;
            end
            else if (walk_active_reg && (cur_reg == last_reg))
            begin
                walk_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= cur_reg;
        wr_blk_reg  <= walk_blk_reg;
        if (cmd.walk_start)
        begin
            case (cmd.seg)
                brapq_pkg::SEG_FIRST:
                begin
                    cur_reg      <= l0;
                    last_reg     <= st.split ? (l0 | BMASK) : r0;
                    walk_blk_reg <= 1'b0;
                end
                brapq_pkg::SEG_BLOCKS:
                begin
                    cur_reg      <= bl_w + EAW'(1);
                    last_reg     <= br_w - EAW'(1);
                    walk_blk_reg <= 1'b1;
                end
                brapq_pkg::SEG_LAST:
                begin
                    cur_reg      <= r0 & ~BMASK;
                    last_reg     <= r0;
                    walk_blk_reg <= 1'b0;
                end
                default:
                begin
                    cur_reg      <= r0;
                    last_reg     <= r0;
                    walk_blk_reg <= 1'b0;
                end
            endcase
        end
        else if (walk_active_reg)
        begin
            cur_reg <= cur_reg + EAW'(1);
        end
    end

    // output register
    always_comb
    begin
        out_next.value  = '0;
        out_next.status = brapq_pkg::STATUS_OK;
        if (st.bad)
        begin
            out_next.status = brapq_pkg::STATUS_BAD;
        end
        else if (st.is_query)
        begin
            out_next.value = $signed(elem_rd_reg + blk_rd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.post)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // checks
    a_no_walk_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !walk_active_reg && !wr_pend_reg)
        else $error("walk active during clearing pass");

    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        walk_active_reg |=> wr_pend_reg)
        else $error("walk read without write-back");

    a_no_rmw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_active_reg && wr_pend_reg && (walk_blk_reg == wr_blk_reg))
        |-> (cur_reg != wr_addr_reg))
        else $error("read and write-back hit the same entry");

    a_post_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> (!out_valid_reg || !out_stall))
        else $error("result posted over a pending item");

endmodule

@@ rtl/blocked_range_add_point_query_unit.sv @@
// ----------------------------------------------------------------------------
// blocked_range_add_point_query_unit: range add / point query over blocks
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_write             cfg_data (size in use)
//   in        in         in_valid / in_stall   in_item  (brapq_pkg::in_item_t)
//   out       out        out_valid / out_stall out_item (brapq_pkg::out_item_t)
//
// After reset a clearing pass zeroes both memories; no item is taken during
// it. One item is in work at a time. A query or a rejected item goes from
// the decision straight to posting its result. Range add: the walker steps
// through each segment entry by entry with a read-modify-write of each entry,
// over 1 to 3 walks (first partial block, whole blocks by their block totals,
// last partial block) before the result is posted; only then is the next item
// taken. A result waits in the output register while the next item is
// accepted.
// ----------------------------------------------------------------------------
module blocked_range_add_point_query_unit
#(
    parameter int MAX_SIZE   = brapq_pkg::MAX_SIZE_DEF,
    parameter int BLOCK_SIZE = brapq_pkg::BLOCK_SIZE_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [brapq_pkg::IDX_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  brapq_pkg::in_item_t           in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output brapq_pkg::out_item_t          out_item
);

    brapq_pkg::dp_cmd_t    cmd;
    brapq_pkg::dp_status_t st;

    brapq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    brapq_dp
    #(
        .MAX_SIZE   (MAX_SIZE),
        .BLOCK_SIZE (BLOCK_SIZE)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
